@@ design/hud_pkg.sv @@
// Shared types and constants for the HCI UART packet deframer.
package hud_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned LEN_W = 16;
   localparam int unsigned HCNT_W = 2;

   localparam logic [BYTE_W-1:0] TYPE_ACL = 8'h02;
   localparam logic [BYTE_W-1:0] TYPE_EVENT = 8'h04;

   localparam logic [HCNT_W-1:0] EVT_HDR_LAST = 2'd1;
   localparam logic [HCNT_W-1:0] ACL_HDR_LAST = 2'd3;
   localparam logic [HCNT_W-1:0] EVT_LEN_POS = 2'd1;
   localparam logic [HCNT_W-1:0] ACL_LEN_LO_POS = 2'd2;
   localparam logic [HCNT_W-1:0] ACL_LEN_HI_POS = 2'd3;

   localparam logic KIND_EVENT = 1'b0;
   localparam logic KIND_ACL = 1'b1;

   typedef enum logic [4:0] {
      PH_TYPE    = 5'b00001,
      PH_EVT_HDR = 5'b00010,
      PH_EVT_PAR = 5'b00100,
      PH_ACL_HDR = 5'b01000,
      PH_ACL_DAT = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              packet_kind;
      logic              is_header;
      logic              end_of_packet;
   } rsp_type;

endpackage

@@ design/hud_if.sv @@
// Request and response channel interfaces for the HCI UART packet deframer.
interface hud_req_if import hud_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface hud_rsp_if import hud_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              packet_kind;
   logic              is_header;
   logic              end_of_packet;

   modport source (output valid, output out_byte, output packet_kind, output is_header,
                   output end_of_packet, input ready);
   modport sink (input valid, input out_byte, input packet_kind, input is_header,
                 input end_of_packet, output ready);
endinterface

@@ design/hci_uart_packet_deframer_unit.sv @@
// HCI UART packet deframer: splits an H4 byte stream into tagged packet bytes.
// Takes one received byte per request and passes on every header and payload
// byte of event (type 0x04) and ACL (type 0x02) packets, tagged with packet
// kind, header flag and end of packet; type bytes and unknown type bytes give
// no response. A request is accepted every cycle while the skid entry is empty;
// the parse state and counters update in the accepting cycle and the response
// goes to the output register, or to the one skid entry behind it if that is
// full; a stalled consumer stops requests only once both are full.
module hci_uart_packet_deframer_unit import hud_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hud_req_if.sink     req_if,
   hud_rsp_if.source   rsp_if
);

   phase_type         phase_ff, phase_in;
   logic [HCNT_W-1:0] hcnt_ff, hcnt_in;
   logic [LEN_W-1:0]  pcnt_ff, pcnt_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;

   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           skid_ff, skid_in;
   logic              skid_valid_ff, skid_valid_in;

   logic              accept;
   logic              produce;
   rsp_type           result;
   logic [LEN_W-1:0]  len_new;
   logic [LEN_W-1:0]  pcnt_new;
   logic              kind;
   logic              hdr_last;
   logic              out_free;

   assign req_if.ready = !skid_valid_ff;
   assign accept = req_if.valid && req_if.ready;

   always_comb begin
      phase_in = phase_ff;
      hcnt_in = hcnt_ff;
      pcnt_in = pcnt_ff;
      plen_in = plen_ff;
      produce = 1'b0;
      kind = (phase_ff inside {PH_ACL_HDR, PH_ACL_DAT}) ? KIND_ACL : KIND_EVENT;
      result.out_byte = req_if.rx_byte;
      result.packet_kind = kind;
      result.is_header = 1'b0;
      result.end_of_packet = 1'b0;
      len_new = plen_ff;
      pcnt_new = pcnt_ff + LEN_W'(1);
      hdr_last = 1'b0;
      case (phase_ff)
         PH_TYPE: begin
            hcnt_in = '0;
            pcnt_in = '0;
            plen_in = '0;
            if (req_if.rx_byte == TYPE_ACL) begin
               phase_in = PH_ACL_HDR;
            end else if (req_if.rx_byte == TYPE_EVENT) begin
               phase_in = PH_EVT_HDR;
            end
         end
         PH_EVT_HDR, PH_ACL_HDR: begin
            produce = 1'b1;
            result.is_header = 1'b1;
            if (kind == KIND_ACL) begin
               if (hcnt_ff == ACL_LEN_LO_POS) begin
                  len_new = {plen_ff[LEN_W-1:BYTE_W], req_if.rx_byte};
               end else if (hcnt_ff == ACL_LEN_HI_POS) begin
                  len_new = {req_if.rx_byte, plen_ff[BYTE_W-1:0]};
               end
               hdr_last = (hcnt_ff == ACL_HDR_LAST);
            end else begin
               if (hcnt_ff == EVT_LEN_POS) begin
                  len_new = LEN_W'(req_if.rx_byte);
               end
               hdr_last = (hcnt_ff == EVT_HDR_LAST);
            end
            plen_in = len_new;
            hcnt_in = hcnt_ff + HCNT_W'(1);
            if (hdr_last) begin
               hcnt_in = '0;
               pcnt_in = '0;
               if (len_new == '0) begin
                  result.end_of_packet = 1'b1;
                  phase_in = PH_TYPE;
                  plen_in = '0;
               end else begin
                  phase_in = (kind == KIND_ACL) ? PH_ACL_DAT : PH_EVT_PAR;
               end
            end
         end
         PH_EVT_PAR, PH_ACL_DAT: begin
            produce = 1'b1;
            pcnt_in = pcnt_new;
            if (pcnt_new == plen_ff) begin
               result.end_of_packet = 1'b1;
               phase_in = PH_TYPE;
               hcnt_in = '0;
               pcnt_in = '0;
               plen_in = '0;
            end
         end
         default: begin
            phase_in = PH_TYPE;
            hcnt_in = '0;
            pcnt_in = '0;
            plen_in = '0;
         end
      endcase
   end

   // Output register with one skid entry behind it.
   assign out_free = !out_valid_ff || rsp_if.ready;

   always_comb begin
      out_in = out_ff;
      out_valid_in = out_valid_ff;
      skid_in = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in = skid_ff;
            out_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in = result;
            out_valid_in = accept && produce;
         end
      end else if (accept && produce) begin
         skid_in = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TYPE;
         hcnt_ff <= '0;
         pcnt_ff <= '0;
         plen_ff <= '0;
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            hcnt_ff <= hcnt_in;
            pcnt_ff <= pcnt_in;
            plen_ff <= plen_in;
         end
         out_valid_ff <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.out_byte = out_ff.out_byte;
   assign rsp_if.packet_kind = out_ff.packet_kind;
   assign rsp_if.is_header = out_ff.is_header;
   assign rsp_if.end_of_packet = out_ff.end_of_packet;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for the HCI UART packet deframer: random H4 byte streams checked against a predictor.
module tb_top;
   import hud_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 3_000_000;
   localparam int unsigned RANDOM_BYTES = 200;
   localparam int unsigned HOLD_AT = 120;
   localparam int unsigned HOLD_CYCLES = 200;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned MAX_REPORTS = 10;

   typedef enum logic [2:0] {
      WAIT_TYPE,
      EVT_HEADER,
      EVT_PARAMS,
      ACL_HEADER,
      ACL_DATA
   } parse_state_type;

   class frame_scoreboard;
      parse_state_type state = WAIT_TYPE;
      logic [2:0]   hdr_taken = '0;
      logic [15:0]  body_taken = '0;
      logic [15:0]  frame_len = '0;
      rsp_type      pending_bytes[$];
      int unsigned  mismatch_count = 0;

      function void restart();
         state = WAIT_TYPE;
         hdr_taken = '0;
         body_taken = '0;
         frame_len = '0;
      endfunction

      function void note_request(logic [7:0] b);
         rsp_type want;
         bit      emits;
         bit      acl;
         emits = 1'b0;
         want = '0;
         want.out_byte = b;
         case (state)
            WAIT_TYPE: begin
               if (b == TYPE_ACL) begin
                  restart();
                  state = ACL_HEADER;
               end else if (b == TYPE_EVENT) begin
                  restart();
                  state = EVT_HEADER;
               end
            end
            EVT_HEADER, ACL_HEADER: begin
               acl = (state == ACL_HEADER);
               want.packet_kind = acl ? KIND_ACL : KIND_EVENT;
               want.is_header = 1'b1;
               emits = 1'b1;
               if (acl) begin
                  if (hdr_taken == 3'd2) frame_len[7:0] = b;
                  else if (hdr_taken == 3'd3) frame_len[15:8] = b;
               end else if (hdr_taken == 3'd1) begin
                  frame_len = {8'h00, b};
               end
               hdr_taken = hdr_taken + 3'd1;
               if (hdr_taken == (acl ? 3'd4 : 3'd2)) begin
                  hdr_taken = '0;
                  body_taken = '0;
                  if (frame_len == 16'd0) begin
                     want.end_of_packet = 1'b1;
                     restart();
                  end else begin
                     state = acl ? ACL_DATA : EVT_PARAMS;
                  end
               end
            end
            EVT_PARAMS, ACL_DATA: begin
               want.packet_kind = (state == ACL_DATA) ? KIND_ACL : KIND_EVENT;
               emits = 1'b1;
               body_taken = body_taken + 16'd1;
               if (body_taken == frame_len) begin
                  want.end_of_packet = 1'b1;
                  restart();
               end
            end
            default: restart();
         endcase
         if (emits) pending_bytes.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: response with nothing expected: byte=%h kind=%b hdr=%b eop=%b",
                        $realtime, got.out_byte, got.packet_kind, got.is_header,
                        got.end_of_packet);
            return;
         end
         want = pending_bytes.pop_front();
         if (got.out_byte !== want.out_byte || got.packet_kind !== want.packet_kind ||
             got.is_header !== want.is_header || got.end_of_packet !== want.end_of_packet) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: expected byte/kind/hdr/eop %h/%b/%b/%b, got %h/%b/%b/%b",
                        $realtime, want.out_byte, want.packet_kind, want.is_header,
                        want.end_of_packet, got.out_byte, got.packet_kind, got.is_header,
                        got.end_of_packet);
         end
      endfunction

      function int unsigned pending();
         return pending_bytes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   hud_req_if req_if();
   hud_rsp_if rsp_if();

   hci_uart_packet_deframer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   frame_scoreboard sb = new();

   int unsigned bytes_sent = 0;
   int unsigned rsp_seen = 0;
   int unsigned cycle_count = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   bit          held = 1'b0;

   logic [7:0] intro_bytes [23] = '{
      8'h00, 8'hFF, 8'h03, 8'h05,
      TYPE_EVENT, 8'h0E, 8'h00,
      TYPE_EVENT, 8'hFF, 8'h01, 8'hA5,
      TYPE_ACL, 8'hFF, 8'hFF, 8'h00, 8'h00,
      TYPE_ACL, 8'h01, 8'h20, 8'h02, 8'h00, 8'h00, 8'hFF
   };

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** hci_uart_packet_deframer_unit: FAILED **");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (bytes_sent % 32 == 0) req_calm = ($urandom_range(0, 3) == 0);
      gap = req_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      sb.note_request(b);
      bytes_sent++;
   endtask

   task automatic send_packet(input logic kind, input int unsigned len, input bit cut);
      logic [7:0]  frame[$];
      int unsigned keep;
      frame.push_back(kind == KIND_ACL ? TYPE_ACL : TYPE_EVENT);
      frame.push_back(8'($urandom_range(0, 255)));
      if (kind == KIND_ACL) begin
         frame.push_back(8'($urandom_range(0, 255)));
         frame.push_back(len[7:0]);
         frame.push_back(len[15:8]);
      end else begin
         frame.push_back(len[7:0]);
      end
      repeat (len) frame.push_back(8'($urandom_range(0, 255)));
      keep = cut ? $urandom_range(1, frame.size() - 1) : frame.size();
      for (int i = 0; i < keep; i++) send_byte(frame[i]);
   endtask

   initial begin
      int unsigned stall;
      rsp_if.ready <= 1'b0;
      @(negedge reset);
      forever begin
         if (rsp_seen % 32 == 0) rsp_calm = ($urandom_range(0, 3) == 0);
         stall = rsp_calm ? 0 : $urandom_range(0, 3);
         if (rsp_seen == HOLD_AT && !held) begin
            stall = HOLD_CYCLES;
            held = 1'b1;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1));
         sb.check_response({rsp_if.out_byte, rsp_if.packet_kind, rsp_if.is_header,
                            rsp_if.end_of_packet});
         rsp_seen++;
      end
   end

   initial begin
      int unsigned target;
      int unsigned pick;
      int unsigned len;
      logic        kind;
      req_if.valid <= 1'b0;
      req_if.rx_byte <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (intro_bytes[i]) send_byte(intro_bytes[i]);

      target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < target) begin
         pick = $urandom_range(0, 9);
         kind = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 19) == 0)
            len = (kind == KIND_ACL) ? $urandom_range(9, 600) : $urandom_range(9, 255);
         else
            len = $urandom_range(0, 8);
         if (pick == 0) send_byte(8'($urandom_range(0, 255)));
         else send_packet(kind, len, pick == 1);
      end

      send_packet(KIND_ACL, 16'h0100, 1'b0);
      send_packet(KIND_EVENT, 0, 1'b0);
      req_if.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatch_count == 0 && sb.pending() == 0)
         $display("** hci_uart_packet_deframer_unit: PASSED **");
      else
         $display("** hci_uart_packet_deframer_unit: FAILED **");
      $finish;
   end

endmodule
